### rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define UCDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define UCDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/ucdp_pkg.sv
// ----------------------------------------------------------------------------
// ucdp_pkg
// Types and constants of the configuration descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ucdp_pkg;

    localparam int MAX_INTERFACES = 32;
    localparam int MAX_ENDPOINTS  = 32;

    localparam logic [7:0] T_DEVICE    = 8'd1;
    localparam logic [7:0] T_CONFIG    = 8'd2;
    localparam logic [7:0] T_INTERFACE = 8'd4;
    localparam logic [7:0] T_ENDPOINT  = 8'd5;

    localparam logic [7:0] MIN_LEN     = 8'd2;
    localparam logic [7:0] FULL_EP_LEN = 8'd7;

    // captured field bytes: offsets 2..7 of a descriptor
    localparam int FLD_LO = 2;
    localparam int FLD_HI = 7;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        K_CONFIG    = 3'd0,
        K_INTERFACE = 3'd1,
        K_ENDPOINT  = 3'd2,
        K_CFG_EXTRA = 3'd3,
        K_IF_EXTRA  = 3'd4,
        K_EP_EXTRA  = 3'd5,
        K_END       = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        E_OK    = 3'd0,
        E_IFS   = 3'd1,
        E_EPS   = 3'd2,
        E_LEN   = 3'd3,
        E_TRUNC = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_CFG    = 2'd1,
        PH_IF     = 2'd2,
        PH_EP     = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  length;
        logic [7:0]  dtype;
        logic [15:0] offset;
        logic [4:0]  if_idx;
        logic [7:0]  alt;
        logic [4:0]  ep_idx;
        logic [15:0] word;
        logic [7:0]  coa;
        logic [7:0]  attr;
        logic [7:0]  ival;
        err_t        err;
    } rec_t;

    // records produced by one byte, toward the record queue
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

`default_nettype wire

### rtl/ucdp_byte_if.sv
// ----------------------------------------------------------------------------
// ucdp_byte_if
// Byte channel: one blob byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       blob_end;

    modport source (output valid, output desc_byte, output blob_end, input ready);
    modport sink   (input valid, input desc_byte, input blob_end, output ready);
endinterface

`default_nettype wire

### rtl/ucdp_rec_if.sv
// ----------------------------------------------------------------------------
// ucdp_rec_if
// Record channel: one parsed descriptor record per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucdp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  rec_kind;
    logic [7:0]  desc_length;
    logic [7:0]  desc_type;
    logic [15:0] desc_offset;
    logic [4:0]  interface_index;
    logic [7:0]  alt_setting;
    logic [4:0]  endpoint_index;
    logic [15:0] word_field;
    logic [7:0]  count_or_addr;
    logic [7:0]  attributes;
    logic [7:0]  interval;
    logic [2:0]  error_code;

    modport source (
        output valid, output rec_kind, output desc_length, output desc_type,
        output desc_offset, output interface_index, output alt_setting,
        output endpoint_index, output word_field, output count_or_addr,
        output attributes, output interval, output error_code,
        input  ready
    );
    modport sink (
        input  valid, input rec_kind, input desc_length, input desc_type,
        input  desc_offset, input interface_index, input alt_setting,
        input  endpoint_index, input word_field, input count_or_addr,
        input  attributes, input interval, input error_code,
        output ready
    );
endinterface

`default_nettype wire

### rtl/usb_config_descriptor_parser.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser
// Walks a configuration descriptor blob byte by byte and reports records.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  byte_ch   in   one blob byte (desc_byte, blob_end)
//  rec_ch    out  one descriptor or end record
//
//  One byte per cycle while byte_ch.ready is high; its records enter a 4-entry queue at the next edge.
//  A byte yields 0..2 records; byte_ch.ready drops while fewer than two
//  queue slots are free, so a stalled rec_ch throttles input once three
//  records wait.
//  rst_n clears the walk and the queue; a byte with blob_end also returns
//  the walk to the header state after that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_config_descriptor_parser import ucdp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ucdp_byte_if.sink   byte_ch,
    ucdp_rec_if.source  rec_ch
);

    push_t push;
    logic  space2;
    logic  step;
    logic  pop;
    rec_t  head;

    assign byte_ch.ready = space2;
    assign step          = byte_ch.valid && byte_ch.ready;
    assign pop           = rec_ch.valid && rec_ch.ready;

    ucdp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .desc_byte (byte_ch.desc_byte),
        .blob_end  (byte_ch.blob_end),
        .push      (push)
    );

    ucdp_rec_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space2     (space2),
        .head_valid (rec_ch.valid),
        .pop        (pop),
        .head       (head)
    );

    assign rec_ch.rec_kind        = head.kind;
    assign rec_ch.desc_length     = head.length;
    assign rec_ch.desc_type       = head.dtype;
    assign rec_ch.desc_offset     = head.offset;
    assign rec_ch.interface_index = head.if_idx;
    assign rec_ch.alt_setting     = head.alt;
    assign rec_ch.endpoint_index  = head.ep_idx;
    assign rec_ch.word_field      = head.word;
    assign rec_ch.count_or_addr   = head.coa;
    assign rec_ch.attributes      = head.attr;
    assign rec_ch.interval        = head.ival;
    assign rec_ch.error_code      = head.err;

endmodule

`default_nettype wire

### rtl/ucdp_walker.sv
// ----------------------------------------------------------------------------
// ucdp_walker
// Walk state and per-byte decode: up to two records per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ucdp_walker import ucdp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] desc_byte,
    input  logic       blob_end,
    output push_t      push
);

    logic [7:0]  byte_pos_reg,   byte_pos_next;
    logic [7:0]  cur_length_reg, cur_length_next;
    logic [7:0]  cur_type_reg,   cur_type_next;
    logic [15:0] remaining_reg,  remaining_next;
    logic [15:0] offset_reg,     offset_next;
    logic [5:0]  if_decl_reg,    if_decl_next;
    logic [5:0]  if_done_reg,    if_done_next;
    logic [5:0]  ep_left_reg,    ep_left_next;
    logic [5:0]  ep_count_reg,   ep_count_next;
    logic [7:0]  cur_alt_reg,    cur_alt_next;
    phase_t      phase_reg,      phase_next;
    logic        stopped_reg,    stopped_next;
    logic [7:0]  fld_reg  [FLD_LO:FLD_HI];
    logic [7:0]  fld_next [FLD_LO:FLD_HI];

    // merged view of fields 2..7 with the current byte; past bLength reads zero
    logic [7:0]  f [FLD_LO:FLD_HI];

    logic        live;
    logic [7:0]  len_c;
    logic [7:0]  type_c;
    logic [7:0]  pos_inc;
    logic        is_hdr;
    logic        bad_len;
    logic        nested;
    logic        early_end;
    logic        cpl;
    logic [15:0] w_hdr;
    logic        hdr_ifs;
    logic        hdr_len;
    logic [15:0] hdr_rem;
    logic [15:0] rem_dec;
    logic        is_if;
    logic        is_ep;
    logic        new_slot;
    logic        if_over;
    logic [5:0]  done_inc;
    logic        if_eps;
    logic        ep_none;
    logic        full_ep;
    logic [5:0]  slot_cur;
    logic [5:0]  ep_last;
    logic        cpl_rec;
    logic        cpl_end;
    err_t        cpl_err;
    logic        walk_end;
    err_t        end_err;
    logic        trunc;
    rec_t        rec_main;
    rec_t        rec_end;

    function automatic rec_t mk_end(err_t e, logic [15:0] off);
        rec_t r;
        r        = '0;
        r.kind   = K_END;
        r.offset = off;
        r.err    = e;
        return r;
    endfunction

    // ---------------- shared decode ----------------
    assign live    = step && !stopped_reg;
    assign len_c   = (byte_pos_reg == 8'd0) ? desc_byte : cur_length_reg;
    assign type_c  = (byte_pos_reg == 8'd1) ? desc_byte : cur_type_reg;
    assign pos_inc = byte_pos_reg + 8'd1;
    assign is_hdr  = (phase_reg == PH_HEADER);

    always_comb
    begin
        for (int i = FLD_LO; i <= FLD_HI; i++)
        begin
            if (8'(i) > byte_pos_reg)
                f[i] = 8'd0;
            else if (8'(i) == byte_pos_reg)
                f[i] = desc_byte;
            else
                f[i] = fld_reg[i];
        end
    end

    assign bad_len   = (byte_pos_reg == 8'd0)
                     && ((desc_byte < MIN_LEN)
                         || (!is_hdr && ({8'd0, desc_byte} > remaining_reg)));
    assign nested    = (byte_pos_reg == 8'd1) && !is_hdr
                     && ((desc_byte == T_CONFIG) || (desc_byte == T_DEVICE));
    assign early_end = bad_len || nested;
    assign cpl       = !early_end && (pos_inc == len_c);

    assign w_hdr   = {f[3], f[2]};
    assign hdr_ifs = f[4] > 8'(MAX_INTERFACES);
    assign hdr_len = {8'd0, len_c} > w_hdr;
    assign hdr_rem = w_hdr - {8'd0, len_c};
    assign rem_dec = remaining_reg - {8'd0, len_c};

    assign is_if    = (type_c == T_INTERFACE);
    assign is_ep    = (type_c == T_ENDPOINT);
    // a nonzero alternate setting reuses the open slot, if one is open
    assign new_slot = !((f[3] != 8'd0) && (if_done_reg != 6'd0));
    assign if_over  = new_slot && (if_done_reg >= if_decl_reg);
    assign done_inc = if_done_reg + {5'd0, new_slot};
    assign if_eps   = f[4] > 8'(MAX_ENDPOINTS);
    assign ep_none  = (ep_left_reg == 6'd0);
    assign full_ep  = len_c >= FULL_EP_LEN;
    assign slot_cur = (if_done_reg == 6'd0) ? 6'd0 : if_done_reg - 6'd1;
    assign ep_last  = (ep_count_reg == 6'd0) ? 6'd0 : ep_count_reg - 6'd1;

    // outcome of a completed descriptor
    always_comb
    begin
        cpl_rec = 1'b1;
        cpl_end = 1'b0;
        cpl_err = E_OK;
        if (is_hdr)
        begin
            priority if (hdr_ifs)
            begin
                cpl_end = 1'b1;
                cpl_err = E_IFS;
            end
            else if (hdr_len)
            begin
                cpl_end = 1'b1;
                cpl_err = E_LEN;
            end
            else if ((f[4] == 8'd0) || (hdr_rem < 16'd2))
            begin
                cpl_end = 1'b1;
            end
            else
            begin
                cpl_end = 1'b0;
            end
        end
        else if (is_if)
        begin
            priority if (if_over)
            begin
                cpl_rec = 1'b0;
                cpl_end = 1'b1;
            end
            else if (if_eps)
            begin
                cpl_end = 1'b1;
                cpl_err = E_EPS;
            end
            else
            begin
                cpl_end = rem_dec < 16'd2;
            end
        end
        else if (is_ep)
        begin
            if (ep_none)
            begin
                cpl_rec = 1'b0;
                cpl_end = 1'b1;
                cpl_err = E_EPS;
            end
            else
            begin
                cpl_end = rem_dec < 16'd2;
            end
        end
        else
        begin
            cpl_end = rem_dec < 16'd2;
        end
    end

    assign walk_end = early_end || (cpl && cpl_end);
    assign end_err  = bad_len ? E_LEN : (early_end ? E_OK : cpl_err);
    assign trunc    = blob_end && !walk_end;

    // ---------------- next state ----------------
    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        cur_length_next = cur_length_reg;
        cur_type_next   = cur_type_reg;
        remaining_next  = remaining_reg;
        offset_next     = offset_reg;
        if_decl_next    = if_decl_reg;
        if_done_next    = if_done_reg;
        ep_left_next    = ep_left_reg;
        ep_count_next   = ep_count_reg;
        cur_alt_next    = cur_alt_reg;
        phase_next      = phase_reg;
        stopped_next    = stopped_reg;
        for (int i = FLD_LO; i <= FLD_HI; i++)
        begin
            fld_next[i] = fld_reg[i];
        end

        if (live)
        begin
            offset_next = offset_reg + 16'd1;
            if (byte_pos_reg == 8'd0)
            begin
                cur_length_next = desc_byte;
                cur_type_next   = 8'd0;
            end
            else if (byte_pos_reg == 8'd1)
            begin
                cur_type_next = desc_byte;
            end

            if (!early_end)
            begin
                for (int i = FLD_LO; i <= FLD_HI; i++)
                begin
                    if (byte_pos_reg == 8'(i))
                        fld_next[i] = desc_byte;
                end
                byte_pos_next = cpl ? 8'd0 : pos_inc;
            end

            if (cpl)
            begin
                if (is_hdr)
                begin
                    if (!hdr_ifs && !hdr_len)
                    begin
                        remaining_next = hdr_rem;
                        if_decl_next   = f[4][5:0];
                        if_done_next   = 6'd0;
                        ep_left_next   = 6'd0;
                        ep_count_next  = 6'd0;
                        cur_alt_next   = 8'd0;
                        phase_next     = PH_CFG;
                    end
                end
                else
                begin
                    remaining_next = rem_dec;
                    if (is_if)
                    begin
                        if (!if_over)
                        begin
                            if_done_next  = done_inc;
                            cur_alt_next  = f[3];
                            ep_count_next = 6'd0;
                            ep_left_next  = if_eps ? 6'd0 : f[4][5:0];
                            if (!if_eps)
                                phase_next = PH_IF;
                        end
                    end
                    else if (is_ep)
                    begin
                        if (!ep_none)
                        begin
                            ep_left_next  = ep_left_reg - 6'd1;
                            ep_count_next = ep_count_reg + 6'd1;
                            phase_next    = PH_EP;
                        end
                    end
                end
            end

            stopped_next = walk_end;
        end

        // last byte of a blob always returns the walk to its start
        if (step && blob_end)
        begin
            byte_pos_next   = 8'd0;
            cur_length_next = 8'd0;
            cur_type_next   = 8'd0;
            remaining_next  = 16'd0;
            offset_next     = 16'd0;
            if_decl_next    = 6'd0;
            if_done_next    = 6'd0;
            ep_left_next    = 6'd0;
            ep_count_next   = 6'd0;
            cur_alt_next    = 8'd0;
            phase_next      = PH_HEADER;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= 8'd0;
            cur_length_reg <= 8'd0;
            cur_type_reg   <= 8'd0;
            remaining_reg  <= 16'd0;
            offset_reg     <= 16'd0;
            if_decl_reg    <= 6'd0;
            if_done_reg    <= 6'd0;
            ep_left_reg    <= 6'd0;
            ep_count_reg   <= 6'd0;
            cur_alt_reg    <= 8'd0;
            phase_reg      <= PH_HEADER;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            cur_length_reg <= cur_length_next;
            cur_type_reg   <= cur_type_next;
            remaining_reg  <= remaining_next;
            offset_reg     <= offset_next;
            if_decl_reg    <= if_decl_next;
            if_done_reg    <= if_done_next;
            ep_left_reg    <= ep_left_next;
            ep_count_reg   <= ep_count_next;
            cur_alt_reg    <= cur_alt_next;
            phase_reg      <= phase_next;
            stopped_reg    <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = FLD_LO; i <= FLD_HI; i++)
        begin
            fld_reg[i] <= fld_next[i];
        end
    end

    // ---------------- record outputs ----------------
    always_comb
    begin
        rec_main        = '0;
        rec_main.length = len_c;
        rec_main.dtype  = type_c;
        rec_main.offset = offset_reg - {8'd0, len_c - 8'd1};
        rec_main.err    = E_OK;
        if (is_hdr)
        begin
            rec_main.kind = K_CONFIG;
            rec_main.word = w_hdr;
            rec_main.coa  = f[4];
            rec_main.attr = f[7];
            rec_main.ival = f[5];
        end
        else if (is_if)
        begin
            rec_main.kind   = K_INTERFACE;
            rec_main.if_idx = 5'(done_inc - 6'd1);
            rec_main.alt    = f[3];
            rec_main.coa    = f[4];
            rec_main.attr   = f[5];
        end
        else if (is_ep)
        begin
            rec_main.kind   = K_ENDPOINT;
            rec_main.if_idx = slot_cur[4:0];
            rec_main.alt    = cur_alt_reg;
            rec_main.ep_idx = ep_count_reg[4:0];
            if (full_ep)
            begin
                rec_main.word = {f[5], f[4]};
                rec_main.coa  = f[2];
                rec_main.attr = f[3];
                rec_main.ival = f[6];
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IF:
                begin
                    rec_main.kind   = K_IF_EXTRA;
                    rec_main.if_idx = slot_cur[4:0];
                    rec_main.alt    = cur_alt_reg;
                end
                PH_EP:
                begin
                    rec_main.kind   = K_EP_EXTRA;
                    rec_main.if_idx = slot_cur[4:0];
                    rec_main.alt    = cur_alt_reg;
                    rec_main.ep_idx = ep_last[4:0];
                end
                PH_HEADER, PH_CFG:
                begin
                    rec_main.kind = K_CFG_EXTRA;
                end
            endcase
        end
    end

    assign rec_end = mk_end(walk_end ? end_err : E_TRUNC, offset_reg);

    always_comb
    begin
        push = '0;
        if (live)
        begin
            if (cpl && cpl_rec)
            begin
                push.rec0 = rec_main;
                push.cnt  = 2'd1;
                if (walk_end || trunc)
                begin
                    push.rec1 = rec_end;
                    push.cnt  = 2'd2;
                end
            end
            else if (walk_end || trunc)
            begin
                push.rec0 = rec_end;
                push.cnt  = 2'd1;
            end
        end
    end

    `UCDP_ASSERT_IMP(a_second_is_end, push.cnt == 2'd2, push.rec1.kind == K_END, "second record of a byte is not an end record")
    `UCDP_ASSERT_IMP(a_hdr_no_slots, phase_reg == PH_HEADER, if_done_reg == 6'd0, "interface slots open before the header")
    `UCDP_ASSERT_IMP(a_quiet_stopped, stopped_reg, push.cnt == 2'd0, "record produced after the walk ended")

endmodule

`default_nettype wire

### rtl/ucdp_rec_fifo.sv
// ----------------------------------------------------------------------------
// ucdp_rec_fifo
// Small record queue; takes up to two records per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ucdp_rec_fifo import ucdp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  space2,
    output logic  head_valid,
    input  logic  pop,
    output rec_t  head
);

    rec_t               rec_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg,  count_next;

    assign space2     = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = rec_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            rec_mem[wr_ptr_reg] <= push.rec0;
        if (push.cnt == 2'd2)
            rec_mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= push.rec1;
    end

    `UCDP_ASSERT(a_count_bound, count_reg <= FIFO_CW'(FIFO_DEPTH), "record queue count over depth")
    `UCDP_ASSERT_IMP(a_no_overflow, push.cnt != 2'd0, ({1'b0, count_reg} + (FIFO_CW + 1)'(push.cnt)) <= (FIFO_CW + 1)'(FIFO_DEPTH), "record queue overflow")
    `UCDP_ASSERT_IMP(a_no_underflow, pop, count_reg != '0, "pop from empty record queue")

endmodule

`default_nettype wire
